@@ rtl/mtke_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: shared package
// Types, codes and character tables for the key decision logic and the
// result buffer.
// ----------------------------------------------------------------------------
package mtke_pkg;

	localparam int FUNC_W    = 2;
	localparam int KEY_W     = 4;
	localparam int TIME_W    = 32;
	localparam int EVENT_W   = 5;
	localparam int CHAR_W    = 7;
	localparam int TAP_W     = 8;
	localparam int MODE_W    = 2;
	localparam int TIMEOUT_W = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [TIMEOUT_W-1:0] TAP_TIMEOUT_RESET = 16'd800;

	localparam logic [MODE_W-1:0] MODE_MENU    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COMPOSE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DEST    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_TIMEOUT = 1'b1;

	localparam logic [KEY_W-1:0] KEY_ZERO = 4'd0;
	localparam logic [KEY_W-1:0] KEY_ONE  = 4'd1;
	localparam logic [KEY_W-1:0] KEY_NINE = 4'd9;
	localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
	localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;
	localparam logic [KEY_W-1:0] NO_KEY   = 4'd15;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK    = 2'd0,
		FUNC_PRESS   = 2'd1,
		FUNC_HOLD    = 2'd2,
		FUNC_RELEASE = 2'd3
	} func_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE         = 5'd0,
		EV_CHAR         = 5'd1,
		EV_DEST_CHAR    = 5'd2,
		EV_COMPOSE_BACK = 5'd3,
		EV_EMERGENCY    = 5'd4,
		EV_INBOX        = 5'd5,
		EV_UP           = 5'd6,
		EV_SENT         = 5'd7,
		EV_NODES        = 5'd8,
		EV_DOWN         = 5'd9,
		EV_NEW_MSG      = 5'd10,
		EV_OUTBOX       = 5'd11,
		EV_BACK         = 5'd12,
		EV_SELECT       = 5'd13,
		EV_SEND         = 5'd14,
		EV_BACKSPACE    = 5'd15,
		EV_SPACE        = 5'd16
	} ev_t;

	typedef struct packed {
		func_t              func;
		logic [KEY_W-1:0]   key_code;
		logic [TIME_W-1:0]  now_ms;
	} key_item_t;

	typedef struct packed {
		ev_t                event_code;
		logic [CHAR_W-1:0]  char_out;
		logic               replace_last;
		logic               last_result;
	} res_t;

	typedef struct packed {
		res_t first;
		res_t second;
		logic two;
	} res_pair_t;

	typedef struct packed {
		logic [KEY_W-1:0]  pending_key;
		logic [TAP_W-1:0]  tap_count;
		logic [TIME_W-1:0] last_tap_time;
		logic [KEY_W-1:0]  held_key;
		logic              hold_done;
	} entry_state_t;

	localparam ev_t MENU_EVENTS [12] = '{
		EV_BACK, EV_INBOX, EV_UP, EV_SENT, EV_UP, EV_NODES,
		EV_DOWN, EV_NEW_MSG, EV_DOWN, EV_OUTBOX, EV_EMERGENCY, EV_SELECT
	};

	// Keys 1, 7 and 9 carry five characters, the others four.
	localparam logic [8:0] TAP_LONG = 9'b101000001;

	localparam logic [CHAR_W-1:0] TAP_CHARS [9][5] = '{
		'{7'h2E, 7'h2C, 7'h21, 7'h3F, 7'h31},
		'{7'h41, 7'h42, 7'h43, 7'h32, 7'h00},
		'{7'h44, 7'h45, 7'h46, 7'h33, 7'h00},
		'{7'h47, 7'h48, 7'h49, 7'h34, 7'h00},
		'{7'h4A, 7'h4B, 7'h4C, 7'h35, 7'h00},
		'{7'h4D, 7'h4E, 7'h4F, 7'h36, 7'h00},
		'{7'h50, 7'h51, 7'h52, 7'h53, 7'h37},
		'{7'h54, 7'h55, 7'h56, 7'h38, 7'h00},
		'{7'h57, 7'h58, 7'h59, 7'h5A, 7'h39}
	};

	// Remainder by five of an 8-bit value; sixteen leaves one, so nibbles fold.
	function automatic logic [2:0] mod5(input logic [TAP_W-1:0] x);
		logic [4:0] s;
		logic [3:0] t;
		logic [3:0] r;
		begin
			s = {1'b0, x[7:4]} + {1'b0, x[3:0]};
			t = {3'd0, s[4]} + s[3:0];
			if (t >= 4'd15) begin
				r = t - 4'd15;
			end else if (t >= 4'd10) begin
				r = t - 4'd10;
			end else if (t >= 4'd5) begin
				r = t - 4'd5;
			end else begin
				r = t;
			end
			return r[2:0];
		end
	endfunction

	function automatic logic [CHAR_W-1:0] tap_char(input logic [KEY_W-1:0] key,
			input logic [TAP_W-1:0] tap);
		logic [3:0]        row;
		logic [2:0]        col;
		logic [CHAR_W-1:0] r;
		begin
			r = '0;
			if (key >= KEY_ONE && key <= KEY_NINE) begin
				row = key - KEY_ONE;
				col = TAP_LONG[row] ? mod5(tap) : {1'b0, tap[1:0]};
				r   = TAP_CHARS[row][col];
			end
			return r;
		end
	endfunction

endpackage

@@ rtl/mtke_if.sv @@
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: channel interfaces
// Key item channel and result item channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface mtke_key_if;
	logic                            valid;
	logic                            ready;
	mtke_pkg::func_t                 func;
	logic [mtke_pkg::KEY_W-1:0]      key_code;
	logic [mtke_pkg::TIME_W-1:0]     now_ms;

	modport source (output valid, func, key_code, now_ms, input ready);
	modport sink   (input valid, func, key_code, now_ms, output ready);
endinterface

interface mtke_res_if;
	logic                            valid;
	logic                            ready;
	logic [mtke_pkg::EVENT_W-1:0]    event_code;
	logic [mtke_pkg::CHAR_W-1:0]     char_out;
	logic                            replace_last;
	logic                            last_result;

	modport source (output valid, event_code, char_out, replace_last, last_result,
		input ready);
	modport sink   (input valid, event_code, char_out, replace_last, last_result,
		output ready);
endinterface

@@ rtl/mtke_decide.sv @@
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: key decision logic
// Works out the results of one key item and the next entry state.
// ----------------------------------------------------------------------------
module mtke_decide import mtke_pkg::*; (
	input  key_item_t              item,
	input  entry_state_t           st,
	input  logic [MODE_W-1:0]      entry_mode,
	input  logic [TIMEOUT_W-1:0]   tap_timeout_ms,
	output entry_state_t           next_st,
	output res_pair_t              results
);

	always_comb begin
		entry_state_t      ns;
		res_t              fl;
		res_t              main_res;
		ev_t               ev;
		logic [CHAR_W-1:0] ch;
		logic              rep;
		logic              text;
		logic              dest;
		logic [TIME_W-1:0] elapsed;
		logic              due;
		logic              flushed;

		ns       = st;
		text     = (entry_mode == MODE_COMPOSE) || (entry_mode == MODE_DEST);
		dest     = (entry_mode == MODE_DEST);
		elapsed  = item.now_ms - st.last_tap_time;
		due      = elapsed >= {16'd0, tap_timeout_ms};
		flushed  = 1'b0;
		fl       = '{EV_NONE, '0, 1'b0, 1'b0};
		ev       = EV_NONE;
		ch       = '0;
		rep      = 1'b0;

		// A pending character whose window has run out goes first.
		if (text && st.pending_key != NO_KEY && due) begin
			fl.event_code   = dest ? EV_DEST_CHAR : EV_CHAR;
			fl.char_out     = tap_char(st.pending_key, st.tap_count - 8'd1);
			fl.replace_last = st.tap_count > 8'd1;
			ns.pending_key  = NO_KEY;
			ns.tap_count    = '0;
			flushed         = 1'b1;
		end

		case (item.func)
			FUNC_HOLD: begin
				if (text && !ns.hold_done) begin
					ns.hold_done   = 1'b1;
					ns.pending_key = NO_KEY;
					ns.tap_count   = '0;
					if (item.key_code == KEY_ZERO) begin
						ev = EV_COMPOSE_BACK;
					end else if (item.key_code == KEY_STAR && !dest) begin
						ev = EV_EMERGENCY;
					end
				end
			end
			FUNC_RELEASE: begin
				if (text && item.key_code == ns.held_key) begin
					ns.held_key  = NO_KEY;
					ns.hold_done = 1'b0;
				end
			end
			FUNC_PRESS: begin
				if (item.key_code <= KEY_HASH) begin
					if (!text) begin
						ev = MENU_EVENTS[item.key_code];
					end else begin
						ns.held_key  = item.key_code;
						ns.hold_done = 1'b0;
						if (item.key_code == KEY_HASH || (item.key_code == KEY_STAR && !dest)) begin
							if (ns.pending_key != NO_KEY) begin
								ev             = dest ? EV_DEST_CHAR : EV_CHAR;
								ch             = tap_char(ns.pending_key, ns.tap_count - 8'd1);
								rep            = ns.tap_count > 8'd1;
								ns.pending_key = NO_KEY;
								ns.tap_count   = '0;
							end else begin
								ev = (item.key_code == KEY_HASH) ? EV_SEND : EV_SPACE;
							end
						end else if (item.key_code == KEY_STAR) begin
							ev = EV_NONE;
						end else if (item.key_code == KEY_ZERO) begin
							if (dest || ns.pending_key == NO_KEY) begin
								ev = EV_BACKSPACE;
							end
							ns.pending_key = NO_KEY;
							ns.tap_count   = '0;
						end else if (item.key_code == ns.pending_key && !due) begin
							ns.tap_count     = ns.tap_count + 8'd1;
							ns.last_tap_time = item.now_ms;
							ev               = dest ? EV_DEST_CHAR : EV_CHAR;
							ch               = tap_char(item.key_code, ns.tap_count - 8'd1);
							rep              = 1'b1;
						end else begin
							if (ns.pending_key != NO_KEY) begin
								ev  = dest ? EV_DEST_CHAR : EV_CHAR;
								ch  = tap_char(ns.pending_key, ns.tap_count - 8'd1);
								rep = ns.tap_count > 8'd1;
							end else begin
								ev  = dest ? EV_DEST_CHAR : EV_CHAR;
								ch  = tap_char(item.key_code, 8'd0);
								rep = 1'b0;
							end
							ns.pending_key   = item.key_code;
							ns.tap_count     = 8'd1;
							ns.last_tap_time = item.now_ms;
						end
					end
				end
			end
			default: begin
			end
		endcase

		main_res = '{ev, ch, rep, 1'b1};
		next_st  = ns;

		if (flushed && item.func == FUNC_TICK) begin
			results.first  = '{fl.event_code, fl.char_out, fl.replace_last, 1'b1};
			results.second = main_res;
			results.two    = 1'b0;
		end else if (flushed) begin
			results.first  = fl;
			results.second = main_res;
			results.two    = 1'b1;
		end else begin
			results.first  = main_res;
			results.second = main_res;
			results.two    = 1'b0;
		end
	end

endmodule

@@ rtl/mtke_res_buf.sv @@
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: result buffer
// Holds the one or two result items of a key item and presents them in order.
// ----------------------------------------------------------------------------
module mtke_res_buf import mtke_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  res_pair_t     pair,
	output logic          can_load,
	mtke_res_if.source    res_ch
);

	res_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       fire;

	assign fire     = res_ch.valid && res_ch.ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && fire);

	assign res_ch.valid        = cnt_q != 2'd0;
	assign res_ch.event_code   = slot_q[0].event_code;
	assign res_ch.char_out     = slot_q[0].char_out;
	assign res_ch.replace_last = slot_q[0].replace_last;
	assign res_ch.last_result  = slot_q[0].last_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= pair.two ? 2'd2 : 2'd1;
		end else if (fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q[0] <= pair.first;
			slot_q[1] <= pair.second;
		end else if (fire) begin
			slot_q[0] <= slot_q[1];
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("Result buffer count out of range.");
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !slot_q[0].last_result)
		else $error("First of two results marked as final.");
	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd1 |-> slot_q[0].last_result)
		else $error("Only remaining result not marked as final.");
`endif

endmodule

@@ rtl/multitap_keypad_text_entry_top.sv @@
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: top level
// Menu navigation and multi-tap character entry from timestamped key items.
// ----------------------------------------------------------------------------
// Key items arrive on key_ch (func, key_code, now_ms) and result items leave
// on res_ch (event_code, char_out, replace_last, last_result), both with
// valid/ready. The write port (wr_en, wr_index, wr_data) sets the entry mode
// (index 0) and the tap timeout (index 1); it must be written only while
// idle, which the block itself does not enforce. An accepted item is held
// in an input register, is decided by single-pass logic and lands in a
// two-entry result buffer, from which its result items are offered. The rate
// is one key item per cycle when each gives a single result and the receiver
// does not stall; an item other than a tick that also flushes a timed-out
// character gives two result items, which leave one after the other on the
// single result port.
// A stalled receiver holds the buffer; the input register then fills and
// ready drops until the buffer drains. Reset empties both registers, selects
// menu mode, sets the timeout to 800 ms and clears all pending tap and hold
// state.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry_top import mtke_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_W-1:0]      wr_data,
	mtke_key_if.sink              key_ch,
	mtke_res_if.source            res_ch
);

	key_item_t             item_s1;
	logic                  valid_s1;
	entry_state_t          state_q;
	entry_state_t          next_st;
	logic [MODE_W-1:0]     mode_q;
	logic [TIMEOUT_W-1:0]  timeout_q;
	res_pair_t             pair;
	logic                  can_load;
	logic                  proc;
	logic                  take;

	assign proc         = valid_s1 && can_load;
	assign key_ch.ready = !valid_s1 || proc;
	assign take         = key_ch.valid && key_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{key_ch.func, key_ch.key_code, key_ch.now_ms};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_MENU;
			timeout_q <= TAP_TIMEOUT_RESET;
			state_q   <= '{NO_KEY, '0, '0, NO_KEY, 1'b0};
		end else if (proc) begin
			state_q <= next_st;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENTRY_MODE: begin
					mode_q              <= wr_data[MODE_W-1:0];
					state_q.pending_key <= NO_KEY;
					state_q.tap_count   <= '0;
					state_q.held_key    <= NO_KEY;
					state_q.hold_done   <= 1'b0;
				end
				REG_TAP_TIMEOUT: begin
					timeout_q <= wr_data[TIMEOUT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	mtke_decide u_decide (
		.item           (item_s1),
		.st             (state_q),
		.entry_mode     (mode_q),
		.tap_timeout_ms (timeout_q),
		.next_st        (next_st),
		.results        (pair)
	);

	mtke_res_buf u_res_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (proc),
		.pair     (pair),
		.can_load (can_load),
		.res_ch   (res_ch)
	);

`ifndef SYNTH
	a_pending_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending_key == NO_KEY
		|| (state_q.pending_key >= KEY_ONE && state_q.pending_key <= KEY_NINE))
		else $error("Pending key is not a character key.");
	a_menu_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_MENU || mode_q == MODE_SPARE) |-> state_q.pending_key == NO_KEY)
		else $error("Pending character held in menu mode.");
	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !can_load |=> valid_s1 && $stable(item_s1))
		else $error("Input item lost while the result buffer was full.");
`endif

endmodule
